// ===== hw/rtl/slrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_pkg
// Shared constants, codes and frame helpers for the segment LCD refresh framer.
// ----------------------------------------------------------------------------
package slrf_pkg;

   localparam int unsigned DISPLAY_DEPTH_DEF = 16;

   localparam int unsigned MODE_W    = 3;
   localparam int unsigned CHANNEL_W = 4;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FRAME_W   = 17;
   localparam int unsigned FLEN_W    = 5;

   localparam int unsigned TIMEOUT_W = 16;
   localparam int unsigned DIGITS_W  = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 16;

   localparam logic [DIGITS_W-1:0] DIGITS_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_STORE     = 3'd0,
      MODE_BACKLIGHT = 3'd1,
      MODE_CLEAR_CNT = 3'd2,
      MODE_TICK      = 3'd3,
      MODE_INIT      = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT     = 2'd0,
      CSR_DIGITS      = 2'd1,
      CSR_ACTIVE_HIGH = 2'd2
   } csr_idx_type;

   // Controller commands.
   localparam logic [BYTE_W-1:0] CMD_BIAS   = 8'h50;
   localparam logic [BYTE_W-1:0] CMD_RC256  = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_SYSDIS = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_WDTDIS = 8'h0A;
   localparam logic [BYTE_W-1:0] CMD_SYSEN  = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_LCDON  = 8'h06;

   localparam logic [FLEN_W-1:0] LEN_NONE = 5'd0;
   localparam logic [FLEN_W-1:0] LEN_CMD  = 5'd12;
   localparam logic [FLEN_W-1:0] LEN_DATA = 5'd17;

   localparam logic [FRAME_W-1:0] CMD_PREFIX  = 17'h00800;
   localparam logic [FRAME_W-1:0] DATA_PREFIX = 17'h14000;

   localparam int unsigned INIT_CMDS = 6;

   function automatic logic [FRAME_W-1:0] cmd_frame(input logic [BYTE_W-1:0] cmd);
      return CMD_PREFIX | {9'd0, cmd};
   endfunction

   // Start-up command sequence, in the order it goes out.
   function automatic logic [BYTE_W-1:0] init_cmd(input logic [2:0] idx);
      logic [BYTE_W-1:0] cmd;
      case (idx)
         3'd0:    cmd = CMD_BIAS;
         3'd1:    cmd = CMD_RC256;
         3'd2:    cmd = CMD_SYSDIS;
         3'd3:    cmd = CMD_WDTDIS;
         3'd4:    cmd = CMD_SYSEN;
         3'd5:    cmd = CMD_LCDON;
         default: cmd = CMD_SYSDIS;
      endcase
      return cmd;
   endfunction

   // Data frame: address is twice the entry index, followed by the byte.
   function automatic logic [FRAME_W-1:0] data_frame(input logic [CHANNEL_W-1:0] idx,
                                                     input logic [BYTE_W-1:0] data);
      return DATA_PREFIX | {4'd0, idx, 1'b0, data};
   endfunction

endpackage

// ===== hw/rtl/slrf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_req_if / slrf_rsp_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface slrf_req_if;
   logic                              valid;
   logic                              ready;
   logic [slrf_pkg::MODE_W-1:0]       mode;
   logic [slrf_pkg::CHANNEL_W-1:0]    channel;
   logic [slrf_pkg::BYTE_W-1:0]       value;
   logic                              light_on;

   modport source (output valid, mode, channel, value, light_on, input ready);
   modport sink   (input valid, mode, channel, value, light_on, output ready);
endinterface

interface slrf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              frame_valid;
   logic [slrf_pkg::FRAME_W-1:0]      frame_bits;
   logic [slrf_pkg::FLEN_W-1:0]       frame_length;
   logic                              backlight_drive;
   logic                              backlight_level;
   logic                              accepted;
   logic                              last;

   modport source (output valid, frame_valid, frame_bits, frame_length, backlight_drive,
                   backlight_level, accepted, last, input ready);
   modport sink   (input valid, frame_valid, frame_bits, frame_length, backlight_drive,
                   backlight_level, accepted, last, output ready);
endinterface

// ===== hw/rtl/slrf_byte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_byte_ram
// Byte-wide synchronous RAM, one write and one registered read port, with
// per-entry valid bits so that unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module slrf_byte_ram #(
   parameter int unsigned DEPTH = slrf_pkg::DISPLAY_DEPTH_DEF,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear_all,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [slrf_pkg::BYTE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [slrf_pkg::BYTE_W-1:0]   rd_data
);
   import slrf_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (clear_all) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/segment_lcd_refresh_framer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_refresh_framer_core
// Display byte store and sent copy kept in RAM, backlight timer, and a
// sequencer that turns ticks and init items into serial frame items.
// ----------------------------------------------------------------------------
// Store, backlight and clear-count items answer from a register, in the cycle after they are accepted.
// A tick compares every entry in use (RAM read, then compare and write back of the sent
// copy); if any changed, each entry in use then gets a RAM read and four frames. Init
// emits six frames. Frame output waits while rsp is not ready. One item is in work at a time.
// Reset is synchronous and clears state.
module segment_lcd_refresh_framer_core #(
   parameter int unsigned DISPLAY_DEPTH = slrf_pkg::DISPLAY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   slrf_req_if.sink                         req_bus,
   slrf_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [slrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slrf_pkg::CSR_W-1:0]       csr_wdata
);
   import slrf_pkg::*;

   localparam int unsigned IDX_W = (DISPLAY_DEPTH > 1) ? $clog2(DISPLAY_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DISPLAY_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_TICK_NONE,
      ST_EMIT_RD,
      ST_EMIT,
      ST_INIT
   } state_type;

   state_type              state_ff;

   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic [DIGITS_W-1:0]    digits_ff;
   logic                   active_high_ff;

   logic                   bl_on_ff;
   logic [TIMEOUT_W-1:0]   tick_cnt_ff;
   logic [TIMEOUT_W-1:0]   tick_cnt_in;

   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       last_idx_ff;
   logic                   changed_ff;
   logic [1:0]             sub_ff;
   logic [2:0]             init_cnt_ff;
   logic                   drive_ff;
   logic                   level_ff;

   logic                   rsp_valid_ff;
   logic                   frame_valid_ff;
   logic [FRAME_W-1:0]     frame_bits_ff;
   logic [FLEN_W-1:0]      frame_length_ff;
   logic                   drive_out_ff;
   logic                   level_out_ff;
   logic                   accepted_ff;
   logic                   last_ff;

   logic                   out_free;
   logic                   req_fire;
   logic [CNT_W-1:0]       used_digits;
   logic                   store_ok;
   logic                   store_wr;
   logic                   sent_wr;
   logic                   clear_store;
   logic                   rd_en;
   logic [BYTE_W-1:0]      store_rd;
   logic [BYTE_W-1:0]      sent_rd;
   logic                   cmp_diff;
   logic                   entry_last;
   logic [FRAME_W-1:0]     emit_frame;
   logic                   tick_quiet;
   logic                   req_walk;
   logic                   req_accepted;
   logic                   rsp_load;

   // Counts above the RAM depth behave as the full depth.
   assign used_digits = (digits_ff > DIGITS_W'(DISPLAY_DEPTH)) ? CNT_W'(DISPLAY_DEPTH)
                                                                : CNT_W'(digits_ff);
   assign store_ok    = DIGITS_W'(req_bus.channel) < DIGITS_W'(used_digits);

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign store_wr    = req_fire && (mode_type'(req_bus.mode) == MODE_STORE) && store_ok;
   assign clear_store = req_fire && (mode_type'(req_bus.mode) == MODE_INIT);
   assign sent_wr     = (state_ff == ST_CMP_CHK);
   assign rd_en       = (state_ff == ST_CMP_RD) || (state_ff == ST_EMIT_RD);
   assign cmp_diff    = store_rd != sent_rd;
   assign entry_last  = idx_ff == last_idx_ff;
   assign tick_cnt_in = tick_cnt_ff + 1'b1;

   // A tick with no entries in use answers at once; other ticks and init walk.
   assign tick_quiet = (mode_type'(req_bus.mode) == MODE_TICK) && (used_digits == '0);
   assign req_walk   = ((mode_type'(req_bus.mode) == MODE_TICK) && (used_digits != '0)) ||
                       (mode_type'(req_bus.mode) == MODE_INIT);

   always_comb begin
      case (mode_type'(req_bus.mode))
         MODE_STORE:                                          req_accepted = store_ok;
         MODE_BACKLIGHT, MODE_CLEAR_CNT, MODE_TICK, MODE_INIT: req_accepted = 1'b1;
         default:                                             req_accepted = 1'b0;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:                       rsp_load = req_fire && !req_walk;
         ST_TICK_NONE, ST_EMIT, ST_INIT: rsp_load = out_free;
         default:                       rsp_load = 1'b0;
      endcase
   end

   always_comb begin
      case (sub_ff)
         2'd0:    emit_frame = cmd_frame(CMD_BIAS);
         2'd1:    emit_frame = cmd_frame(CMD_SYSEN);
         2'd2:    emit_frame = cmd_frame(CMD_LCDON);
         default: emit_frame = data_frame(CHANNEL_W'(idx_ff), store_rd);
      endcase
   end

   slrf_byte_ram #(.DEPTH(DISPLAY_DEPTH)) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_store),
      .wr_en     (store_wr),
      .wr_idx    (req_bus.channel[IDX_W-1:0]),
      .wr_data   (req_bus.value),
      .rd_en     (rd_en),
      .rd_idx    (idx_ff),
      .rd_data   (store_rd)
   );

   // The sent copy is only written back during the compare pass, in the check state
   // after that entry's read, so a read never meets a pending write to the same entry.
   slrf_byte_ram #(.DEPTH(DISPLAY_DEPTH)) u_sent (
      .clock     (clock),
      .reset     (reset),
      .clear_all (1'b0),
      .wr_en     (sent_wr),
      .wr_idx    (idx_ff),
      .wr_data   (store_rd),
      .rd_en     (state_ff == ST_CMP_RD),
      .rd_idx    (idx_ff),
      .rd_data   (sent_rd)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= '0;
         digits_ff      <= DIGITS_RESET;
         active_high_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_TIMEOUT:     timeout_ff     <= csr_wdata[TIMEOUT_W-1:0];
            CSR_DIGITS:      digits_ff      <= csr_wdata[DIGITS_W-1:0];
            CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bl_on_ff        <= 1'b0;
         tick_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         idx_ff          <= '0;
         last_idx_ff     <= '0;
         changed_ff      <= 1'b0;
         sub_ff          <= '0;
         init_cnt_ff     <= '0;
         drive_ff        <= 1'b0;
         level_ff        <= 1'b0;
         frame_valid_ff  <= 1'b0;
         frame_bits_ff   <= '0;
         frame_length_ff <= LEN_NONE;
         drive_out_ff    <= 1'b0;
         level_out_ff    <= 1'b0;
         accepted_ff     <= 1'b0;
         last_ff         <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  // One item with no frame; a tick walk or init replaces it later.
                  frame_valid_ff  <= 1'b0;
                  frame_bits_ff   <= '0;
                  frame_length_ff <= LEN_NONE;
                  drive_out_ff    <= tick_quiet && !bl_on_ff;
                  level_out_ff    <= tick_quiet && !bl_on_ff && !active_high_ff;
                  accepted_ff     <= req_accepted;
                  last_ff         <= 1'b1;
                  case (mode_type'(req_bus.mode))
                     MODE_BACKLIGHT: begin
                        bl_on_ff <= req_bus.light_on;
                     end
                     MODE_CLEAR_CNT: begin
                        tick_cnt_ff <= '0;
                     end
                     MODE_TICK: begin
                        drive_ff <= !bl_on_ff;
                        level_ff <= !bl_on_ff && !active_high_ff;
                        if (bl_on_ff) begin
                           if (tick_cnt_in > timeout_ff) begin
                              tick_cnt_ff <= '0;
                              bl_on_ff    <= 1'b0;
                           end else begin
                              tick_cnt_ff <= tick_cnt_in;
                           end
                        end
                        if (used_digits != '0) begin
                           idx_ff       <= '0;
                           last_idx_ff  <= IDX_W'(used_digits - 1'b1);
                           changed_ff   <= 1'b0;
                           state_ff     <= ST_CMP_RD;
                        end
                     end
                     MODE_INIT: begin
                        bl_on_ff     <= 1'b0;
                        init_cnt_ff  <= '0;
                        state_ff     <= ST_INIT;
                     end
                     default: ;
                  endcase
               end
            end

            ST_CMP_RD: begin
               state_ff <= ST_CMP_CHK;
            end

            ST_CMP_CHK: begin
               if (entry_last) begin
                  idx_ff   <= '0;
                  state_ff <= (changed_ff || cmp_diff) ? ST_EMIT_RD : ST_TICK_NONE;
               end else begin
                  changed_ff <= changed_ff || cmp_diff;
                  idx_ff     <= idx_ff + 1'b1;
                  state_ff   <= ST_CMP_RD;
               end
            end

            ST_TICK_NONE: begin
               if (out_free) begin
                  frame_valid_ff  <= 1'b0;
                  frame_bits_ff   <= '0;
                  frame_length_ff <= LEN_NONE;
                  drive_out_ff    <= drive_ff;
                  level_out_ff    <= level_ff;
                  accepted_ff     <= 1'b1;
                  last_ff         <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end

            ST_EMIT_RD: begin
               sub_ff   <= '0;
               state_ff <= ST_EMIT;
            end

            ST_EMIT: begin
               if (out_free) begin
                  frame_valid_ff  <= 1'b1;
                  frame_bits_ff   <= emit_frame;
                  frame_length_ff <= (sub_ff == 2'd3) ? LEN_DATA : LEN_CMD;
                  drive_out_ff    <= drive_ff;
                  level_out_ff    <= level_ff;
                  accepted_ff     <= 1'b1;
                  last_ff         <= (sub_ff == 2'd3) && entry_last;
                  sub_ff          <= sub_ff + 1'b1;
                  if (sub_ff == 2'd3) begin
                     if (entry_last) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        idx_ff   <= idx_ff + 1'b1;
                        state_ff <= ST_EMIT_RD;
                     end
                  end
               end
            end

            ST_INIT: begin
               if (out_free) begin
                  frame_valid_ff  <= 1'b1;
                  frame_bits_ff   <= cmd_frame(init_cmd(init_cnt_ff));
                  frame_length_ff <= LEN_CMD;
                  drive_out_ff    <= 1'b0;
                  level_out_ff    <= 1'b0;
                  accepted_ff     <= 1'b1;
                  last_ff         <= init_cnt_ff == 3'(INIT_CMDS - 1);
                  init_cnt_ff     <= init_cnt_ff + 1'b1;
                  if (init_cnt_ff == 3'(INIT_CMDS - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.frame_valid     = frame_valid_ff;
   assign rsp_bus.frame_bits      = frame_bits_ff;
   assign rsp_bus.frame_length    = frame_length_ff;
   assign rsp_bus.backlight_drive = drive_out_ff;
   assign rsp_bus.backlight_level = level_out_ff;
   assign rsp_bus.accepted        = accepted_ff;
   assign rsp_bus.last            = last_ff;

endmodule

// ===== hw/rtl/slrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_checker
// Port-level checks on the response channel of the refresh framer.
// ----------------------------------------------------------------------------
module slrf_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             frame_valid,
   input  logic [slrf_pkg::FRAME_W-1:0]     frame_bits,
   input  logic [slrf_pkg::FLEN_W-1:0]      frame_length,
   input  logic                             accepted,
   input  logic                             last
);
   import slrf_pkg::*;

   // A stalled response stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its frame.
   a_rsp_hold_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(frame_bits) && $stable(frame_length))
      else $error("response frame changed while stalled");

   // An item without a frame carries zero bits and zero length.
   a_no_frame_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_valid |-> frame_bits == '0 && frame_length == LEN_NONE)
      else $error("frameless item carries frame data");

   // Frames are either 12-bit commands or 17-bit data writes with the write prefix.
   a_frame_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_valid |->
         (frame_length == LEN_CMD && frame_bits[16:8] == 9'h008) ||
         (frame_length == LEN_DATA && frame_bits[16:14] == 3'b101))
      else $error("malformed frame");

   // A rejected item is a single frameless response.
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !accepted |-> !frame_valid && last)
      else $error("rejected item produced frames");

endmodule

bind segment_lcd_refresh_framer_core slrf_checker u_slrf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .frame_valid  (rsp_bus.frame_valid),
   .frame_bits   (rsp_bus.frame_bits),
   .frame_length (rsp_bus.frame_length),
   .accepted     (rsp_bus.accepted),
   .last         (rsp_bus.last)
);
